// ----- rtl/core/r2h_pkg.sv -----
// r2h_pkg: shared types, sector codes and hue offsets for the RGB to HSV converter.
// Used by r2h_front, r2h_queue, r2h_back and rgb_to_hsv_converter.
// No dependencies.
package r2h_pkg;

  // Division widths: hue quotient is at most 7680, saturation at most 255
  localparam int HUE_STEPS = 13;
  localparam int SAT_STEPS = 8;

  // Hue sector, red tested first, then green, then blue
  localparam logic [1:0] SECT_RED      = 2'd0;
  localparam logic [1:0] SECT_RED_WRAP = 2'd1;
  localparam logic [1:0] SECT_GREEN    = 2'd2;
  localparam logic [1:0] SECT_BLUE     = 2'd3;

  // Classified pixel with both long divisions set up
  typedef struct packed {
    logic [7:0]           hue_rem;   // partial remainder, always below hue_div
    logic [HUE_STEPS-1:0] hue_bits;  // numerator bits left, quotient bits shifted in
    logic [7:0]           hue_div;   // chroma
    logic [7:0]           sat_rem;
    logic [SAT_STEPS-1:0] sat_bits;
    logic [1:0]           sector;
    logic                 gray;
    logic [7:0]           brightness; // also the saturation divisor
  } item_t;

  // Sector base minus one sector (3840), modulo 2^16
  function automatic logic [15:0] hue_offset(input logic [1:0] sector);
    logic [15:0] offs;
    unique case (sector)
      SECT_RED:      offs = 16'd61696;  // -3840
      SECT_RED_WRAP: offs = 16'd19200;  // 23040 - 3840
      SECT_GREEN:    offs = 16'd3840;   // 7680 - 3840
      SECT_BLUE:     offs = 16'd11520;  // 15360 - 3840
      default:       offs = 16'd0;
    endcase
    return offs;
  endfunction

endpackage

// ----- rtl/core/rgb_to_hsv_converter.sv -----
// rgb_to_hsv_converter: top level, front classifier, queue and divider back end.
// Depends on r2h_pkg, r2h_front, r2h_queue, r2h_back.
//
//   channel  | dir | signals                  | contents
//   ---------+-----+--------------------------+------------------------------
//   pixel in | in  | s_tvalid/s_tready/s_tdata| red, green, blue
//   hsv out  | out | m_tvalid/m_tready/m_tdata| hue, saturation, brightness
//            |     | m_tuser                  | is_gray
//
// One pixel per clock sustained while m_tready is high. Registers along the path:
// one front register, one queue write, the divider input register, 13 hue divider
// stages (the saturation divider shares the first 8) and the result register.
// rst is synchronous; it empties the front register, queue and pipeline.
// A stall on m_tready freezes the divider pipeline; the queue keeps filling and
// s_tready drops once it and the front register are full.
module rgb_to_hsv_converter #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // hue [14:0], saturation [22:15], brightness [30:23], 0
  output logic [0:0]  m_tuser    // is_gray [0]
);

  logic           fq_valid, fq_ready, qb_valid, qb_ready;
  r2h_pkg::item_t fq_item, qb_item;
  logic [14:0]    hue;
  logic [7:0]     saturation, brightness;
  logic           is_gray;

  r2h_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .red       (s_tdata[7:0]),
    .green     (s_tdata[15:8]),
    .blue      (s_tdata[23:16]),
    .out_valid (fq_valid),
    .out_ready (fq_ready),
    .out_item  (fq_item)
  );

  r2h_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_item   (fq_item),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_item  (qb_item)
  );

  r2h_back u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (qb_valid),
    .in_ready   (qb_ready),
    .in_item    (qb_item),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .is_gray    (is_gray)
  );

  // Output packing
  assign m_tdata = {1'b0, brightness, saturation, hue};
  assign m_tuser = is_gray;

endmodule

// ----- rtl/core/r2h_front.sv -----
// r2h_front: takes pixel transfers, finds max, min, chroma and sector,
// and sets up the hue and saturation divisions. Depends on r2h_pkg.
module r2h_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          red,
  input  logic [7:0]          green,
  input  logic [7:0]          blue,
  output logic                out_valid,
  input  logic                out_ready,
  output r2h_pkg::item_t      out_item
);

  logic                      vld;
  r2h_pkg::item_t            item;
  r2h_pkg::item_t            item_next;

  logic [7:0]  mx, mn, chroma, pos, neg;
  logic [1:0]  sector;
  logic [9:0]  diff, shifted;
  logic [12:0] hue_mul;
  logic [20:0] hue_num;
  logic [15:0] sat_num;

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;
  assign out_item  = item;

  // Classification
  always_comb begin
    mx = red;
    if (green > mx) mx = green;
    if (blue > mx)  mx = blue;
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn)  mn = blue;
    chroma = mx - mn;

    if (mx == red) begin
      pos = green;
      neg = blue;
    end else if (mx == green) begin
      pos = blue;
      neg = red;
    end else begin
      pos = red;
      neg = green;
    end
    diff = {2'b00, pos} - {2'b00, neg};

    if (mx == red) begin
      sector = (green < blue) ? r2h_pkg::SECT_RED_WRAP : r2h_pkg::SECT_RED;
    end else if (mx == green) begin
      sector = r2h_pkg::SECT_GREEN;
    end else begin
      sector = r2h_pkg::SECT_BLUE;
    end

    // shifted = diff + chroma lies in [0, 2*chroma]; numerator is 3840*shifted
    shifted = diff + {2'b00, chroma};
    hue_mul = {4'b0000, shifted[8:0]} * 13'd15;
    hue_num = {hue_mul, 8'h00};
    sat_num = {chroma, 8'h00} - {8'h00, chroma};

    item_next.hue_rem    = hue_num[20:13];
    item_next.hue_bits   = hue_num[12:0];
    item_next.hue_div    = chroma;
    item_next.sat_rem    = sat_num[15:8];
    item_next.sat_bits   = sat_num[7:0];
    item_next.sector     = sector;
    item_next.gray       = (chroma == 8'd0);
    item_next.brightness = mx;
  end

  // Holding register toward the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= item_next;
    end
  end

endmodule

// ----- rtl/core/r2h_queue.sv -----
// r2h_queue: small FIFO of classified pixels between front and back.
// Depends on r2h_pkg.
module r2h_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  r2h_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output r2h_pkg::item_t out_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  r2h_pkg::item_t mem [DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;
  logic           push, pop;

  assign in_ready  = (count != CW'(DEPTH));
  assign out_valid = (count != '0);
  assign out_item  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/r2h_back.sv -----
// r2h_back: pipelined restoring dividers, one quotient bit per stage, and
// the result register. Depends on r2h_pkg.
module r2h_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  r2h_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [14:0]    hue,
  output logic [7:0]     saturation,
  output logic [7:0]     brightness,
  output logic           is_gray
);

  localparam int NST = r2h_pkg::HUE_STEPS;

  logic [NST:0]   vld;
  r2h_pkg::item_t st [NST+1];
  r2h_pkg::item_t st_next [NST];
  logic           en;
  r2h_pkg::item_t last;
  logic [15:0]    hue_sum;

  // Whole pipeline moves unless the result register is full and stalled
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // One division step per stage
  for (genvar k = 0; k < NST; k++) begin : g_step
    logic [8:0] ht, st9;
    logic       hge, sge;
    always_comb begin
      st_next[k] = st[k];
      ht  = {st[k].hue_rem, st[k].hue_bits[NST-1]};
      hge = (ht >= {1'b0, st[k].hue_div});
      st_next[k].hue_rem  = hge ? 8'(ht - {1'b0, st[k].hue_div}) : ht[7:0];
      st_next[k].hue_bits = {st[k].hue_bits[NST-2:0], hge};
      st9 = {st[k].sat_rem, st[k].sat_bits[r2h_pkg::SAT_STEPS-1]};
      sge = (st9 >= {1'b0, st[k].brightness});
      if (k < r2h_pkg::SAT_STEPS) begin
        st_next[k].sat_rem  = sge ? 8'(st9 - {1'b0, st[k].brightness}) : st9[7:0];
        st_next[k].sat_bits = {st[k].sat_bits[r2h_pkg::SAT_STEPS-2:0], sge};
      end
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[NST-1:0], in_valid};
      out_valid <= vld[NST];
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= in_item;
      for (int k = 0; k < NST; k++) begin
        st[k+1] <= st_next[k];
      end
    end
  end

  // Final hue add and gray masking
  assign last    = st[NST];
  assign hue_sum = r2h_pkg::hue_offset(last.sector) + {3'b000, last.hue_bits};

  always_ff @(posedge clk) begin
    if (en) begin
      hue        <= last.gray ? 15'd0 : hue_sum[14:0];
      saturation <= last.gray ? 8'd0 : last.sat_bits;
      brightness <= last.brightness;
      is_gray    <= last.gray;
    end
  end

endmodule

// ----- test/tb_top.sv -----
// tb_top: self-checking testbench for rgb_to_hsv_converter.
// Drives pixels through the stream input, predicts hue, saturation and value
// for each one, and checks every output transfer in order.
`timescale 1ns / 100ps

module tb_top;

  localparam int NUM_DIR    = 24;
  localparam int NUM_RAND   = 2000;
  localparam int HUE_SECT   = 3840;   // 60 degrees in 1/64 degree units
  localparam int HUE_WRAP   = 23040;  // 360 degrees
  localparam int DRAIN_WAIT = 40;

  // Expected converter output
  typedef struct packed {
    logic [14:0] hue;
    logic [7:0]  sat;
    logic [7:0]  bright;
    logic        gray;
  } hsv_t;

  // One row of the directed table; known rows carry a hand-written result
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       known;
    hsv_t       want;
  } pixel_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // red [7:0], green [15:8], blue [23:16]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // hue [14:0], saturation [22:15], brightness [30:23], 0
  logic [0:0]  m_tuser;        // is_gray [0]

  hsv_t        pending_hsv[$];
  int          error_cnt   = 0;
  int          pixel_cnt   = 0;
  int          checked_cnt = 0;
  int          gray_cnt    = 0;
  int          wrap_cnt    = 0;
  int          hold_cnt    = 0;
  int          rx_roll;
  logic [11:0] cycle_cnt   = '0;
  logic        tx_burst    = 1'b0;

  // Directed pixels: black, white and grays, primaries and secondaries,
  // sector ties, red-sector wrap and one-step chroma
  pixel_row_t dir_rows [NUM_DIR] = '{
    '{8'd0,   8'd0,   8'd0,   1'b1, '{15'd0,     8'd0,   8'd0,   1'b1}},
    '{8'd255, 8'd255, 8'd255, 1'b1, '{15'd0,     8'd0,   8'd255, 1'b1}},
    '{8'd128, 8'd128, 8'd128, 1'b1, '{15'd0,     8'd0,   8'd128, 1'b1}},
    '{8'd1,   8'd1,   8'd1,   1'b1, '{15'd0,     8'd0,   8'd1,   1'b1}},
    '{8'd255, 8'd0,   8'd0,   1'b1, '{15'd0,     8'd255, 8'd255, 1'b0}},
    '{8'd0,   8'd255, 8'd0,   1'b1, '{15'd7680,  8'd255, 8'd255, 1'b0}},
    '{8'd0,   8'd0,   8'd255, 1'b1, '{15'd15360, 8'd255, 8'd255, 1'b0}},
    '{8'd255, 8'd255, 8'd0,   1'b1, '{15'd3840,  8'd255, 8'd255, 1'b0}},
    '{8'd0,   8'd255, 8'd255, 1'b1, '{15'd11520, 8'd255, 8'd255, 1'b0}},
    '{8'd255, 8'd0,   8'd255, 1'b1, '{15'd19200, 8'd255, 8'd255, 1'b0}},
    '{8'd255, 8'd0,   8'd1,   1'b0, '0},
    '{8'd1,   8'd0,   8'd0,   1'b1, '{15'd0,     8'd255, 8'd1,   1'b0}},
    '{8'd0,   8'd1,   8'd0,   1'b1, '{15'd7680,  8'd255, 8'd1,   1'b0}},
    '{8'd0,   8'd0,   8'd1,   1'b1, '{15'd15360, 8'd255, 8'd1,   1'b0}},
    '{8'd255, 8'd254, 8'd254, 1'b0, '0},
    '{8'd254, 8'd255, 8'd255, 1'b0, '0},
    '{8'd128, 8'd64,  8'd200, 1'b0, '0},
    '{8'd200, 8'd200, 8'd100, 1'b0, '0},
    '{8'd50,  8'd200, 8'd200, 1'b0, '0},
    '{8'd200, 8'd50,  8'd200, 1'b0, '0},
    '{8'd255, 8'd255, 8'd254, 1'b0, '0},
    '{8'd1,   8'd0,   8'd1,   1'b0, '0},
    '{8'd170, 8'd85,  8'd0,   1'b0, '0},
    '{8'd0,   8'd170, 8'd255, 1'b0, '0}
  };

  rgb_to_hsv_converter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hue, saturation and value of one pixel, exact integer math, hue floored
  function automatic hsv_t hsv_of(input logic [7:0] red, input logic [7:0] green,
                                  input logic [7:0] blue);
    int   vmax, vmin, chroma, diff, base, hue;
    hsv_t res;
    vmax = int'(red);
    vmin = int'(red);
    if (int'(green) > vmax) vmax = int'(green);
    if (int'(blue) > vmax) vmax = int'(blue);
    if (int'(green) < vmin) vmin = int'(green);
    if (int'(blue) < vmin) vmin = int'(blue);
    chroma = vmax - vmin;
    hue = 0;
    if (chroma != 0) begin
      // red wins ties, then green
      if (vmax == int'(red)) begin
        diff = int'(green) - int'(blue);
        base = (diff < 0) ? HUE_WRAP : 0;
      end else if (vmax == int'(green)) begin
        diff = int'(blue) - int'(red);
        base = 2 * HUE_SECT;
      end else begin
        diff = int'(red) - int'(green);
        base = 4 * HUE_SECT;
      end
      hue = base - HUE_SECT + (HUE_SECT * (diff + chroma)) / chroma;
    end
    res.hue    = hue[14:0];
    res.sat    = (vmax != 0) ? 8'((chroma * 255) / vmax) : 8'd0;
    res.bright = vmax[7:0];
    res.gray   = (chroma == 0);
    return res;
  endfunction

  // Random idle before a pixel: mostly none, some short, a few long
  task automatic sender_gap();
    int roll, gap;
    roll = $urandom_range(0, 99);
    gap  = 0;
    if (!tx_burst) begin
      if (roll >= 90) gap = $urandom_range(10, 40);
      else if (roll >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Present one pixel and hold it until the transfer completes
  task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                            input logic [7:0] blue, input hsv_t want);
    s_tvalid <= 1'b1;
    s_tdata  <= {blue, green, red};
    do @(posedge clk); while (!s_tready);
    pending_hsv.push_back(want);
    pixel_cnt++;
  endtask

  // Stop sending until every expected result has come out
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_hsv.size() != 0) @(posedge clk);
  endtask

  // Output side: check each transfer, then pick the next ready level
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1'b1;
    if (m_tvalid && m_tready) begin
      if (pending_hsv.size() == 0) begin
        $display("%0t: unexpected result hue %0d sat %0d value %0d gray %0d", $time,
                 m_tdata[14:0], m_tdata[22:15], m_tdata[30:23], m_tuser[0]);
        error_cnt++;
      end else begin
        hsv_t want;
        want = pending_hsv.pop_front();
        if (m_tdata[14:0] !== want.hue || m_tdata[22:15] !== want.sat ||
            m_tdata[30:23] !== want.bright || m_tuser[0] !== want.gray ||
            m_tdata[31] !== 1'b0) begin
          $display("%0t: mismatch expected hue %0d sat %0d value %0d gray %0d pad 0",
                   $time, want.hue, want.sat, want.bright, want.gray);
          $display("%0t:          actual hue %0d sat %0d value %0d gray %0d pad %0d",
                   $time, m_tdata[14:0], m_tdata[22:15], m_tdata[30:23], m_tuser[0],
                   m_tdata[31]);
          error_cnt++;
        end
        checked_cnt++;
        if (want.gray) gray_cnt++;
        if (want.hue >= 15'(HUE_WRAP - HUE_SECT)) wrap_cnt++;
      end
    end
    // while cycle_cnt[11:10] is 2'b11, ready goes high once a hold ends
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      m_tready <= 1'b0;
    end else if (cycle_cnt[11:10] == 2'b11) begin
      m_tready <= 1'b1;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (rx_roll < 65) begin
        m_tready <= 1'b1;
      end else if (rx_roll < 95) begin
        m_tready <= 1'b0;
        hold_cnt <= $urandom_range(0, 2);
      end else begin
        m_tready <= 1'b0;
        hold_cnt <= $urandom_range(8, 40);
      end
    end
  end

  // Stimulus
  initial begin
    logic [7:0] red, green, blue;
    int         mode;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int i = 0; i < NUM_DIR; i++) begin
      sender_gap();
      send_pixel(dir_rows[i].red, dir_rows[i].green, dir_rows[i].blue,
                 dir_rows[i].known ? dir_rows[i].want :
                 hsv_of(dir_rows[i].red, dir_rows[i].green, dir_rows[i].blue));
    end
    drain_results();

    // random pixels, biased toward grays, ties and channel extremes
    for (int i = 0; i < NUM_RAND; i++) begin
      tx_burst = ((i / 300) % 4) == 3;
      if (i == NUM_RAND / 2) drain_results();
      mode  = $urandom_range(0, 99);
      red   = 8'($urandom_range(0, 255));
      green = 8'($urandom_range(0, 255));
      blue  = 8'($urandom_range(0, 255));
      if (mode < 10) begin
        green = red;
        blue  = red;
      end else if (mode < 25) begin
        case ($urandom_range(0, 2))
          0:       green = red;
          1:       blue = green;
          default: blue = red;
        endcase
      end else if (mode < 40) begin
        case ($urandom_range(0, 3))
          0:       red = 8'd0;
          1:       red = 8'd255;
          2:       green = 8'd0;
          default: blue = 8'd255;
        endcase
        if ($urandom_range(0, 1) == 1) green = $urandom_range(0, 1) ? 8'd255 : 8'd1;
      end
      sender_gap();
      send_pixel(red, green, blue, hsv_of(red, green, blue));
    end

    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Converted %0d pixels (%0d directed), checked %0d results:", pixel_cnt,
             NUM_DIR, checked_cnt);
    $display("  %0d gray, %0d wrapped red-sector hues, %0d mismatches", gray_cnt,
             wrap_cnt, error_cnt);
    if (error_cnt == 0 && pending_hsv.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog, far above the slowest correct run
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/r2h_pkg.sv
rtl/core/r2h_front.sv
rtl/core/r2h_queue.sv
rtl/core/r2h_back.sv
rtl/core/rgb_to_hsv_converter.sv
test/tb_top.sv
